// ===== rtl/streaming_kth_order_statistic_core_defines.svh =====
// Assertion macros for the streaming k-th order statistic core.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef STREAMING_KTH_ORDER_STATISTIC_CORE_DEFINES_SVH
`define STREAMING_KTH_ORDER_STATISTIC_CORE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define KOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kos: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define KOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kos: next-cycle check failed");

`endif

// ===== rtl/kos_pkg.sv =====
// Shared widths, register indexes and defaults for the k-th order statistic core.
// Stand-alone package; used by streaming_kth_order_statistic_core.
`default_nettype none

package kos_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W     = 32;
    localparam int RANK_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Default depth of the kept set
    localparam int K_MAX_DEFAULT = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANK_K          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_SMALLEST = 2'd1;

    // Reset values of the configuration registers
    localparam logic [RANK_W-1:0] RANK_K_RESET          = 5'd1;
    localparam logic              SELECT_SMALLEST_RESET = 1'b1;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_index;

endpackage

`default_nettype wire

// ===== rtl/streaming_kth_order_statistic_core.sv =====
// Streaming k-th order statistic core: sorted kept set with parallel insert.
// Depends on kos_pkg and streaming_kth_order_statistic_core_defines.svh.
//
// The core takes one signed 32-bit sample per request and keeps the k
// smallest (select_smallest = 1) or k largest (select_smallest = 0) samples
// of the current array in a register array sorted in ascending order. The
// whole compare-and-shift insertion is combinational between the input
// register and the kept-set registers, so throughput is one sample per
// clock while the input is not stalled. A sample flagged end_of_array
// yields one result, the worst kept value (the k-th order statistic), by
// way of the input register and then the result register. Such a sample
// waits in the input register, and new requests stall, while the result
// register still holds an untaken result. fewer_than_k is set when the
// array held fewer than k samples. The kept set is emptied after every
// array. rank_k is clamped to 1..K_MAX. Configuration writes take effect
// at once and are meant for idle periods.
`default_nettype none

module streaming_kth_order_statistic_core #(
    parameter int K_MAX = kos_pkg::K_MAX_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire kos_pkg::t_cfg_index  i_cfg_index,
    input  wire kos_pkg::t_cfg_data   i_cfg_wdata,
    // sample requests
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire kos_pkg::t_sample     i_sample_value,
    input  wire logic                 i_end_of_array,
    // result requests
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output kos_pkg::t_sample          o_kth_value,
    output logic                      o_fewer_than_k
);

    import kos_pkg::*;
    `include "streaming_kth_order_statistic_core_defines.svh"

    localparam int CW = $clog2(K_MAX + 1);
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int EW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [EW-1:0] KMAX_E = EW'(K_MAX);

    // Configuration registers
    logic [RANK_W-1:0] r_rank_k;
    logic              r_sel_small;

    // Input stage
    logic              r_s1_valid;
    t_sample           r_s1_value;
    logic              r_s1_last;

    // Kept set and fill count
    t_sample           r_kept [K_MAX];
    logic [CW-1:0]     r_cnt;

    // Result register
    logic              r_out_valid;
    t_sample           r_out_kth;
    logic              r_out_fewer;

    // Combinational datapath
    logic              out_free;
    logic              s1_go;
    logic [EW-1:0]     rank_e;
    logic [CW-1:0]     k_eff;
    logic              over;
    logic [CW-1:0]     cnt_t;
    logic [CW-1:0]     drop_n;
    logic [CW:0]       src [K_MAX];
    t_sample           t_v [K_MAX];
    logic [K_MAX-1:0]  le_m;
    t_sample           ins_v [K_MAX];
    t_sample           rep_v [K_MAX];
    t_sample           n_kept [K_MAX];
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     lpos;
    logic [CW-1:0]     wpos;
    t_sample           worst;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_k    <= RANK_K_RESET;
            r_sel_small <= SELECT_SMALLEST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RANK_K:          r_rank_k    <= i_cfg_wdata[RANK_W-1:0];
                REG_SELECT_SMALLEST: r_sel_small <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance the input stage unless its result has nowhere to go
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_value <= i_sample_value;
            r_s1_last  <= i_end_of_array;
        end
    end

    // Clamp the rank to 1..K_MAX
    always_comb begin
        rank_e = EW'(r_rank_k);
        if (rank_e == '0) begin
            k_eff = CW'(1);
        end else if (rank_e > KMAX_E) begin
            k_eff = CW'(K_MAX);
        end else begin
            k_eff = rank_e[CW-1:0];
        end
    end

    // Trim the set down to k; in largest mode drop from the low end
    always_comb begin
        over   = r_cnt > k_eff;
        cnt_t  = over ? k_eff : r_cnt;
        drop_n = (over && !r_sel_small) ? (r_cnt - k_eff) : '0;
        for (int i = 0; i < K_MAX; i++) begin
            src[i] = (CW + 1)'(i) + {1'b0, drop_n};
            if (src[i] < (CW + 1)'(K_MAX)) begin
                t_v[i] = r_kept[src[i][IW-1:0]];
            end else begin
                t_v[i] = r_kept[i];
            end
        end
    end

    // Compare the sample against every valid entry; true entries form a prefix
    always_comb begin
        for (int i = 0; i < K_MAX; i++) begin
            le_m[i] = (t_v[i] <= r_s1_value) && (CW'(i) < cnt_t);
        end
    end

    // Insert with shift up; the entry past the end falls off
    always_comb begin
        ins_v[0] = le_m[0] ? t_v[0] : r_s1_value;
        for (int i = 1; i < K_MAX; i++) begin
            if (le_m[i]) begin
                ins_v[i] = t_v[i];
            end else if (le_m[i-1]) begin
                ins_v[i] = r_s1_value;
            end else begin
                ins_v[i] = t_v[i-1];
            end
        end
    end

    // Replace the lowest entry: shift down below the insert point
    always_comb begin
        for (int i = 0; i < K_MAX - 1; i++) begin
            if (le_m[i+1]) begin
                rep_v[i] = t_v[i+1];
            end else if (le_m[i]) begin
                rep_v[i] = r_s1_value;
            end else begin
                rep_v[i] = t_v[i];
            end
        end
        rep_v[K_MAX-1] = le_m[K_MAX-1] ? r_s1_value : t_v[K_MAX-1];
    end

    // Choose the update for this sample and pick the worst kept value
    always_comb begin
        lpos = cnt_t - CW'(1);
        if (cnt_t < k_eff) begin
            n_kept = ins_v;
            n_cnt  = cnt_t + CW'(1);
        end else if (r_sel_small) begin
            if (le_m[lpos[IW-1:0]]) begin
                n_kept = t_v;
            end else begin
                n_kept = ins_v;
            end
            n_cnt  = cnt_t;
        end else begin
            if (t_v[0] < r_s1_value) begin
                n_kept = rep_v;
            end else begin
                n_kept = t_v;
            end
            n_cnt  = cnt_t;
        end
        wpos  = n_cnt - CW'(1);
        worst = r_sel_small ? n_kept[wpos[IW-1:0]] : n_kept[0];
    end

    // Update the kept set; empty it after the last sample of an array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s1_go) begin
            r_cnt <= r_s1_last ? '0 : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_kept <= n_kept;
        end
    end

    // Load the result register; drop the request once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_kth   <= worst;
            r_out_fewer <= n_cnt < k_eff;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kth_value    = r_out_kth;
    assign o_fewer_than_k = r_out_fewer;

    // Checks on the internal control
    `KOS_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(K_MAX))
    `KOS_ASSERT_NEXT(a_cnt_clear, i_clk, i_rst_n, s1_go && r_s1_last, r_cnt == '0)
    `KOS_ASSERT_NEXT(a_cnt_step, i_clk, i_rst_n, s1_go, {1'b0, r_cnt} <= {1'b0, $past(r_cnt)} + (CW + 1)'(1))
    `KOS_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_s1_last)
    `KOS_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, r_out_valid && i_out_stall, !(s1_go && r_s1_last))

endmodule

`default_nettype wire

// ===== tb/tb_streaming_kth_order_statistic_core.sv =====
// Self-checking bench for the streaming k-th order statistic core.
// Needs kos_pkg and the core; a scoreboard class predicts each array result.
`default_nettype none

module tb_streaming_kth_order_statistic_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kos_pkg::*;

    localparam int DEPTH          = K_MAX_DEFAULT;
    localparam int RANDOM_ITEMS   = 600;
    localparam int QUIET_TAIL_AT  = 500;
    localparam int HOLD_CYCLES    = 60;
    localparam int PIPE_SETTLE    = 4;
    localparam t_cfg_index REG_SPARE_2 = 2'd2;
    localparam t_cfg_index REG_SPARE_3 = 2'd3;
    localparam t_sample SAMPLE_MAX = 32'sh7fff_ffff;
    localparam t_sample SAMPLE_MIN = 32'sh8000_0000;

    typedef struct {
        t_sample kth_value;
        logic    fewer_than_k;
    } t_kth_result;

    // Mirror of the kept set; predicts the order statistic of every array
    class kth_select_scoreboard;
        t_sample           kept_set[DEPTH];
        int                kept_count;
        logic [RANK_W-1:0] rank_k;
        logic              select_smallest;
        t_kth_result       expected_results[$];
        int unsigned       mismatches;

        function new();
            kept_count      = 0;
            rank_k          = RANK_K_RESET;
            select_smallest = SELECT_SMALLEST_RESET;
            mismatches      = 0;
        endfunction

        function void write_reg(t_cfg_index idx, t_cfg_data data);
            case (idx)
                REG_RANK_K:          rank_k = data;
                REG_SELECT_SMALLEST: select_smallest = data[0];
                default: ;
            endcase
        endfunction

        // Clamp the rank to 1..DEPTH
        function int effective_rank();
            int k;
            k = rank_k;
            if (k < 1) k = 1;
            if (k > DEPTH) k = DEPTH;
            return k;
        endfunction

        // Insert after any equal entries, keeping ascending order
        function void insert_sorted(t_sample v);
            int pos;
            pos = 0;
            while (pos < kept_count && kept_set[pos] <= v) pos++;
            for (int i = kept_count; i > pos; i--) kept_set[i] = kept_set[i-1];
            kept_set[pos] = v;
            kept_count++;
        endfunction

        function void drop_lowest();
            for (int i = 0; i + 1 < kept_count; i++) kept_set[i] = kept_set[i+1];
            kept_count--;
        endfunction

        function void note_sample(t_sample v, logic is_last);
            int          k;
            t_kth_result r;
            k = effective_rank();
            // trim down to k when the rank was lowered mid-array
            while (kept_count > k) begin
                if (select_smallest) kept_count--;
                else drop_lowest();
            end
            if (kept_count < k) begin
                insert_sorted(v);
            end else if (select_smallest) begin
                if (v < kept_set[kept_count-1]) begin
                    kept_count--;
                    insert_sorted(v);
                end
            end else if (v > kept_set[0]) begin
                drop_lowest();
                insert_sorted(v);
            end
            if (is_last) begin
                r.kth_value    = select_smallest ? kept_set[kept_count-1] : kept_set[0];
                r.fewer_than_k = (kept_count < k);
                expected_results.push_back(r);
                kept_count = 0;
            end
        endfunction

        function void check_result(t_sample kth_value, logic fewer_than_k);
            t_kth_result r;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kth_value=%0d fewer_than_k=%0b",
                         $time, kth_value, fewer_than_k);
                mismatches++;
                return;
            end
            r = expected_results.pop_front();
            if (kth_value !== r.kth_value) begin
                $display("%0t: kth_value expected %0d actual %0d",
                         $time, r.kth_value, kth_value);
                mismatches++;
            end
            if (fewer_than_k !== r.fewer_than_k) begin
                $display("%0t: fewer_than_k expected %0b actual %0b",
                         $time, r.fewer_than_k, fewer_than_k);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    t_cfg_data  i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_sample    i_sample_value;
    logic       i_end_of_array;
    logic       o_out_valid;
    logic       i_out_stall;
    t_sample    o_kth_value;
    logic       o_fewer_than_k;

    kth_select_scoreboard order_stats = new();
    bit idle_on       = 1'b1;
    int out_hold_left = 0;
    int items_sent    = 0;

    streaming_kth_order_statistic_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_end_of_array (i_end_of_array),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kth_value    (o_kth_value),
        .o_fewer_than_k (o_fewer_than_k)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a result never shows up
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Sample both handshakes mid-cycle, where every signal has settled
    always @(negedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            order_stats.note_sample(i_sample_value, i_end_of_array);
        if (i_rst_n && o_out_valid && !i_out_stall)
            order_stats.check_result(o_kth_value, o_fewer_than_k);
    end

    // Result side: long hold-off on request, else short random stall bursts
    initial begin
        int burst_left;
        burst_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_hold_left > 0) begin
                out_hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(1, 3) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_sample pick_value();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return t_sample'($urandom_range(0, 15)) - 8;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RANK_W'(DEPTH);
            2:       return RANK_W'($urandom_range(DEPTH + 1, 31));
            3:       return RANK_W'(1);
            default: return RANK_W'($urandom_range(1, DEPTH));
        endcase
    endfunction

    // Write one register; the core takes it at this edge
    task automatic write_reg(input t_cfg_index idx, input t_cfg_data data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        order_stats.write_reg(idx, data);
    endtask

    // Program rank and mode; junk in the upper mode bits must be ignored
    task automatic set_config(input logic [RANK_W-1:0] rank, input logic smallest,
                              input logic poke_spare);
        t_cfg_data junk;
        junk = t_cfg_data'($urandom);
        write_reg(REG_RANK_K, rank);
        write_reg(REG_SELECT_SMALLEST, {junk[CFG_DATA_W-1:1], smallest});
        if (poke_spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      t_cfg_data'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample request, with an optional idle burst ahead of it
    task automatic send_sample(input t_sample value, input logic is_last);
        logic taken;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        i_end_of_array <= is_last;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    // Hold the input until every pending result is out and the pipe is empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (order_stats.expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int len;
        int cut;
        int phase;
        int first_random;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_RANK_K;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_sample_value <= '0;
        i_end_of_array <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: k = 1, smallest, single-sample arrays at the extremes
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        drain_results();

        // Short array flags fewer than k; then a run of equal values
        set_config(RANK_W'(3), 1'b1, 1'b1);
        send_sample(5, 1'b0);
        send_sample(-2, 1'b1);
        repeat (3) send_sample(7, 1'b0);
        send_sample(7, 1'b1);
        drain_results();

        // Rank zero acts as one, largest mode
        set_config('0, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(0, 1'b1);
        drain_results();

        // Rank beyond depth clamps to the depth
        set_config(RANK_W'(31), 1'b1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        drain_results();

        // Lower the rank mid-array; the worst entries get dropped
        set_config(RANK_W'(4), 1'b1, 1'b0);
        send_sample(9, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(12, 1'b0);
        send_sample(4, 1'b0);
        drain_results();
        set_config(RANK_W'(2), 1'b1, 1'b0);
        send_sample(20, 1'b1);
        drain_results();

        // Flip the mode mid-array; the kept set stays as it is
        set_config(RANK_W'(3), 1'b1, 1'b0);
        send_sample(6, 1'b0);
        send_sample(-8, 1'b0);
        send_sample(2, 1'b0);
        drain_results();
        set_config(RANK_W'(3), 1'b0, 1'b1);
        send_sample(3, 1'b1);
        drain_results();

        // Random phases: new settings, a few arrays each, idle between phases
        first_random = items_sent;
        phase = 0;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            idle_on = (items_sent - first_random < QUIET_TAIL_AT) &&
                      ($urandom_range(0, 3) != 0);
            set_config(pick_rank(), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // block the result side and keep offering samples so that the input stalls
                out_hold_left = HOLD_CYCLES;
                repeat (12) send_sample(pick_value(), 1'b1);
            end else begin
                repeat ($urandom_range(2, 6)) begin
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(1, 24);
                    else
                        len = $urandom_range(1, order_stats.effective_rank() + 3);
                    cut = (len > 1 && $urandom_range(0, 9) == 0) ?
                          $urandom_range(1, len - 1) : 0;
                    for (int n = 0; n < len; n++) begin
                        if (cut != 0 && n == cut) begin
                            drain_results();
                            set_config(pick_rank(), 1'($urandom_range(0, 1)), 1'b0);
                        end
                        send_sample(pick_value(), n == len - 1);
                    end
                end
            end
            drain_results();
            phase++;
        end

        repeat (10) @(posedge i_clk);
        if (order_stats.mismatches == 0 && order_stats.expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/kos_pkg.sv
rtl/streaming_kth_order_statistic_core.sv
tb/tb_streaming_kth_order_statistic_core.sv
